// ===== rtl/tricycle_kinematic_rates_defines.svh =====
// Assertion macros for the tricycle kinematic rate block.
// Included by the top level; no other dependencies.
`ifndef TRICYCLE_KINEMATIC_RATES_DEFINES_SVH
`define TRICYCLE_KINEMATIC_RATES_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

// ===== rtl/trk_pkg.sv =====
// Shared types, constants and the arctangent table for the tricycle rate block.
// No dependencies.
package trk_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int DATA_BITS   = 16;
   localparam int WB_BITS     = 16;
   localparam int PHASE_BITS  = 32;
   localparam int CORDIC_BITS = 32;
   localparam int WB_FRAC     = 12;

   localparam logic [WB_BITS-1:0] IWB_RESET = 16'd4096;
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_INV_GAIN = 32'sd652032874;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] heading_angle;
      logic signed [ANGLE_BITS-1:0] steer_angle;
      logic signed [DATA_BITS-1:0]  drive_speed;
      logic signed [DATA_BITS-1:0]  steer_rate_in;
   } trk_req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] x_rate;
      logic signed [DATA_BITS-1:0] y_rate;
      logic signed [DATA_BITS-1:0] heading_rate;
      logic signed [DATA_BITS-1:0] steer_rate_out;
      logic                        saturated;
   } trk_rsp_type;

   // atan(2^-i) as a fraction of a full turn, 2^32 per turn
   function automatic logic [PHASE_BITS-1:0] atan_entry(input logic [4:0] idx);
      logic [PHASE_BITS-1:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/trk_cordic.sv =====
// Pipelined rotation CORDIC: one register stage per iteration, then quadrant fold.
// Depends on trk_pkg.
module trk_cordic #(
   parameter int TRIG_STAGES = 14
) (
   input  logic                                    clock,
   input  logic signed [trk_pkg::ANGLE_BITS-1:0]   angle,
   output logic signed [trk_pkg::CORDIC_BITS-1:0]  cos_out,
   output logic signed [trk_pkg::CORDIC_BITS-1:0]  sin_out
);
   import trk_pkg::*;

   logic [PHASE_BITS-1:0]         phase;
   logic signed [CORDIC_BITS-1:0] x_ff [TRIG_STAGES];
   logic signed [CORDIC_BITS-1:0] y_ff [TRIG_STAGES];
   logic [PHASE_BITS-1:0]         z_ff [TRIG_STAGES];
   logic [1:0]                    quad_ff [TRIG_STAGES];
   logic signed [CORDIC_BITS-1:0] cos_ff, sin_ff;
   logic signed [CORDIC_BITS-1:0] cos_in, sin_in;

   assign phase = {angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
      logic signed [CORDIC_BITS-1:0] x_src, y_src, dx, dy;
      logic [PHASE_BITS-1:0]         z_src;
      logic [1:0]                    q_src;
      if (i == 0) begin : g_first
         assign x_src = CORDIC_INV_GAIN;
         assign y_src = '0;
         assign z_src = {2'b00, phase[PHASE_BITS-3:0]};
         assign q_src = phase[PHASE_BITS-1:PHASE_BITS-2];
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
         assign q_src = quad_ff[i-1];
      end
      assign dx = y_src >>> i;
      assign dy = x_src >>> i;
      always_ff @(posedge clock) begin
         if (!z_src[PHASE_BITS-1]) begin
            x_ff[i] <= x_src - dx;
            y_ff[i] <= y_src + dy;
            z_ff[i] <= z_src - atan_entry(5'(i));
         end else begin
            x_ff[i] <= x_src + dx;
            y_ff[i] <= y_src - dy;
            z_ff[i] <= z_src + atan_entry(5'(i));
         end
         quad_ff[i] <= q_src;
      end
   end

   always_comb begin
      unique case (quad_ff[TRIG_STAGES-1])
         QUAD_FIRST: begin
            cos_in = x_ff[TRIG_STAGES-1];
            sin_in = y_ff[TRIG_STAGES-1];
         end
         QUAD_SECOND: begin
            cos_in = -y_ff[TRIG_STAGES-1];
            sin_in = x_ff[TRIG_STAGES-1];
         end
         QUAD_THIRD: begin
            cos_in = -x_ff[TRIG_STAGES-1];
            sin_in = -y_ff[TRIG_STAGES-1];
         end
         QUAD_FOURTH: begin
            cos_in = y_ff[TRIG_STAGES-1];
            sin_in = -x_ff[TRIG_STAGES-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== rtl/trk_scale.sv =====
// Four-stage multiply, round and saturate pipeline producing the rate beat.
// Depends on trk_pkg.
module trk_scale (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [trk_pkg::CORDIC_BITS-1:0]  cos_head,
   input  logic signed [trk_pkg::CORDIC_BITS-1:0]  sin_head,
   input  logic signed [trk_pkg::CORDIC_BITS-1:0]  cos_steer,
   input  logic signed [trk_pkg::CORDIC_BITS-1:0]  sin_steer,
   input  logic signed [trk_pkg::DATA_BITS-1:0]    speed,
   input  logic signed [trk_pkg::DATA_BITS-1:0]    rate,
   input  logic [trk_pkg::WB_BITS-1:0]             inv_wheelbase,
   output logic                                    out_valid,
   output trk_pkg::trk_rsp_type                    out_data
);
   import trk_pkg::*;

   localparam int PROD_BITS = 2 * CORDIC_BITS;
   localparam int TS_BITS   = DATA_BITS + CORDIC_BITS;
   localparam int CC_BITS   = CORDIC_BITS + 1;
   localparam int T_BITS    = DATA_BITS + 1;
   localparam int XP_BITS   = DATA_BITS + CC_BITS;
   localparam int HP_BITS   = 2 * T_BITS;
   localparam int SAT_BITS  = 24;
   localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'((1 << (DATA_BITS-1)) - 1);
   localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_BITS'(1 << (DATA_BITS-1));

   // {clip, value}
   function automatic logic [DATA_BITS:0] sat_data(input logic signed [SAT_BITS-1:0] v);
      logic [DATA_BITS:0] r;
      if (v > SAT_HI)
         r = {1'b1, SAT_HI[DATA_BITS-1:0]};
      else if (v < SAT_LO)
         r = {1'b1, SAT_LO[DATA_BITS-1:0]};
      else
         r = {1'b0, v[DATA_BITS-1:0]};
      return r;
   endfunction

   // stage 1
   logic                          v1_ff;
   logic signed [PROD_BITS-1:0]   hc_ff, hs_ff;
   logic signed [TS_BITS-1:0]     ts_ff;
   logic signed [DATA_BITS-1:0]   speed1_ff, rate1_ff;
   // stage 2
   logic                          v2_ff;
   logic signed [CC_BITS-1:0]     cc_ff, cs_ff;
   logic signed [T_BITS-1:0]      t_ff;
   logic signed [DATA_BITS-1:0]   speed2_ff, rate2_ff;
   logic signed [PROD_BITS-1:0]   hc_rnd, hs_rnd;
   logic signed [TS_BITS-1:0]     ts_rnd;
   // stage 3
   logic                          v3_ff;
   logic signed [XP_BITS-1:0]     xp_ff, yp_ff;
   logic signed [HP_BITS-1:0]     hp_ff;
   logic signed [DATA_BITS-1:0]   rate3_ff;
   logic signed [T_BITS-1:0]      iwb_s;
   // stage 4
   logic                          v4_ff;
   trk_rsp_type                   rsp_ff;
   logic signed [XP_BITS-1:0]     xp_rnd, yp_rnd;
   logic signed [HP_BITS-1:0]     hp_rnd;
   logic [DATA_BITS:0]            xs, ys, hs;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      hc_ff     <= cos_steer * cos_head;
      hs_ff     <= cos_steer * sin_head;
      ts_ff     <= speed * sin_steer;
      speed1_ff <= speed;
      rate1_ff  <= rate;
   end

   assign hc_rnd = hc_ff + (PROD_BITS'(1) <<< 29);
   assign hs_rnd = hs_ff + (PROD_BITS'(1) <<< 29);
   assign ts_rnd = ts_ff + (TS_BITS'(1) <<< 29);

   always_ff @(posedge clock) begin
      cc_ff     <= hc_rnd[30 +: CC_BITS];
      cs_ff     <= hs_rnd[30 +: CC_BITS];
      t_ff      <= ts_rnd[30 +: T_BITS];
      speed2_ff <= speed1_ff;
      rate2_ff  <= rate1_ff;
   end

   assign iwb_s = $signed({1'b0, inv_wheelbase});

   always_ff @(posedge clock) begin
      xp_ff    <= speed2_ff * cc_ff;
      yp_ff    <= speed2_ff * cs_ff;
      hp_ff    <= t_ff * iwb_s;
      rate3_ff <= rate2_ff;
   end

   assign xp_rnd = xp_ff + (XP_BITS'(1) <<< 29);
   assign yp_rnd = yp_ff + (XP_BITS'(1) <<< 29);
   assign hp_rnd = hp_ff + (HP_BITS'(1) <<< (WB_FRAC - 1));

   assign xs = sat_data(SAT_BITS'($signed(xp_rnd[XP_BITS-1:30])));
   assign ys = sat_data(SAT_BITS'($signed(yp_rnd[XP_BITS-1:30])));
   assign hs = sat_data(SAT_BITS'($signed(hp_rnd[HP_BITS-1:WB_FRAC])));

   always_ff @(posedge clock) begin
      rsp_ff.x_rate         <= xs[DATA_BITS-1:0];
      rsp_ff.y_rate         <= ys[DATA_BITS-1:0];
      rsp_ff.heading_rate   <= hs[DATA_BITS-1:0];
      rsp_ff.steer_rate_out <= rate3_ff;
      rsp_ff.saturated      <= xs[DATA_BITS] | ys[DATA_BITS] | hs[DATA_BITS];
   end

   assign out_valid = v4_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== rtl/tricycle_kinematic_rates.sv =====
// Top level of the tricycle kinematic rate block: config register, two CORDICs, scaling.
// Depends on trk_pkg, trk_cordic, trk_scale and tricycle_kinematic_rates_defines.svh.
//
//   channel   ports                         handshake
//   request   start, busy, req_data         beat taken when start && !busy
//   response  rsp_strobe, rsp_data          one-cycle strobe, no back-pressure
//   csr       csr_valid, csr_ready, csr_data  write when valid && ready
//
// One beat per cycle outside reset. The path runs through one register per CORDIC iteration,
// one for the quadrant fold, and four for the multiply and round stages.
// busy is high only during reset; the pipeline never stalls.
// Synchronous reset clears the valid bits and loads the wheelbase reciprocal with 1.0.
`include "tricycle_kinematic_rates_defines.svh"
module tricycle_kinematic_rates #(
   parameter int TRIG_STAGES = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  trk_pkg::trk_req_type          req_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [trk_pkg::WB_BITS-1:0]   csr_data,
   output logic                          rsp_strobe,
   output trk_pkg::trk_rsp_type          rsp_data
);
   import trk_pkg::*;

   localparam int SIDE_DEPTH = TRIG_STAGES + 1;
   localparam int LATENCY    = TRIG_STAGES + 5;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] speed;
      logic signed [DATA_BITS-1:0] rate;
   } trk_side_type;

   logic                          accept;
   logic [WB_BITS-1:0]            inverse_wheelbase_ff;
   logic                          side_valid_ff [SIDE_DEPTH];
   trk_side_type                  side_ff [SIDE_DEPTH];
   logic signed [CORDIC_BITS-1:0] cos_head, sin_head, cos_steer, sin_steer;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_wheelbase_ff <= IWB_RESET;
      end else if (csr_valid && csr_ready) begin
         inverse_wheelbase_ff <= csr_data;
      end
   end

   // speed and rate ride alongside the CORDIC stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIDE_DEPTH; i++) begin
            side_valid_ff[i] <= 1'b0;
         end
      end else begin
         side_valid_ff[0] <= accept;
         for (int i = 1; i < SIDE_DEPTH; i++) begin
            side_valid_ff[i] <= side_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0].speed <= req_data.drive_speed;
      side_ff[0].rate  <= req_data.steer_rate_in;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   trk_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_head (
      .clock   (clock),
      .angle   (req_data.heading_angle),
      .cos_out (cos_head),
      .sin_out (sin_head)
   );

   trk_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_steer (
      .clock   (clock),
      .angle   (req_data.steer_angle),
      .cos_out (cos_steer),
      .sin_out (sin_steer)
   );

   trk_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (side_valid_ff[SIDE_DEPTH-1]),
      .cos_head      (cos_head),
      .sin_head      (sin_head),
      .cos_steer     (cos_steer),
      .sin_steer     (sin_steer),
      .speed         (side_ff[SIDE_DEPTH-1].speed),
      .rate          (side_ff[SIDE_DEPTH-1].rate),
      .inv_wheelbase (inverse_wheelbase_ff),
      .out_valid     (rsp_strobe),
      .out_data      (rsp_data)
   );

   `ASSERT_IMPLIES(a_beat_emerges, clock, reset, accept, ##LATENCY rsp_strobe)
   `ASSERT_IMPLIES(a_strobe_has_source, clock, reset, rsp_strobe, $past(accept, LATENCY))
   `ASSERT_IMPLIES(a_rate_aligned, clock, reset, rsp_strobe, rsp_data.steer_rate_out == $past(req_data.steer_rate_in, LATENCY))
   `ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe)

endmodule
